// ===== rtl/sha256bc_pkg.sv =====
package sha256bc_pkg;

    localparam int NumIv      = 8;
    localparam int BlockWords = 16;
    localparam int Rounds     = 64;
    localparam int WordW      = 32;
    localparam int CfgIdxW    = 4;
    localparam int IvIdxW     = $clog2(NumIv);
    localparam int WordCntW   = $clog2(BlockWords);
    localparam int RoundW     = $clog2(Rounds);

    typedef logic [WordW-1:0]   t_word;
    typedef logic [CfgIdxW-1:0] t_cfg_index;

    // Highest configuration index that maps to an IV register
    localparam t_cfg_index CfgIvLast = t_cfg_index'(NumIv - 1);

    localparam logic [WordCntW-1:0] LastWord  = WordCntW'(BlockWords - 1);
    localparam logic [RoundW-1:0]   LastRound = RoundW'(Rounds - 1);

    typedef struct packed {
        logic [31:0] message_word;
        logic        new_message;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_01;
        logic [63:0] digest_23;
        logic [63:0] digest_45;
        logic [63:0] digest_67;
    } t_out_item;

    typedef enum logic [1:0] {
        S_LOAD,
        S_ROUND,
        S_FINAL
    } t_state;

    localparam t_word StdIv [NumIv] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word RoundK [Rounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word big_sigma0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    function automatic t_word choose(input t_word e, input t_word f, input t_word g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic t_word majority(input t_word a, input t_word b, input t_word c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

// ===== rtl/sha256_block_compression.sv =====
// SHA-256 compression engine. Padded message words enter one beat at a time,
// sixteen beats to a 512-bit block; new_message on a beat reloads the hash
// state from the IV registers before that word is taken. After the sixteenth
// word the input stalls while a single round unit runs the 64 rounds, one per
// cycle, with the message schedule computed on the fly in a 16-word window;
// a final state then adds the working variables into the hash state and loads
// the digest into the output register. The digest waits there while the next
// block's words load; the engine holds in its final state only if the previous
// digest is still untaken. IV writes affect only the next reload, never the
// running hash.
module sha256_block_compression (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  sha256bc_pkg::t_in_item    i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output sha256bc_pkg::t_out_item   o_out_data,
    input  logic                      i_cfg_we,
    input  sha256bc_pkg::t_cfg_index  i_cfg_index,
    input  sha256bc_pkg::t_word       i_cfg_data
);
    import sha256bc_pkg::*;

    t_state                r_state, n_state;
    logic [WordCntW-1:0]   r_word_cnt, n_word_cnt;
    logic [RoundW-1:0]     r_round, n_round;
    logic                  r_out_valid, n_out_valid;
    t_word                 r_iv   [NumIv];
    t_word                 r_hash [NumIv];
    t_word                 n_hash [NumIv];
    t_word                 r_v    [NumIv];
    t_word                 n_v    [NumIv];
    t_word                 r_win  [BlockWords];
    t_word                 n_win  [BlockWords];
    t_out_item             r_out, n_out;

    logic  in_acc;
    logic  out_free;
    t_word t1, t2, w_next;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Round datapath: shared by all 64 rounds
    always_comb begin
        t1 = r_v[7] + big_sigma1(r_v[4]) + choose(r_v[4], r_v[5], r_v[6])
           + RoundK[r_round] + r_win[0];
        t2 = big_sigma0(r_v[0]) + majority(r_v[0], r_v[1], r_v[2]);
        w_next = small_sigma1(r_win[14]) + r_win[9] + small_sigma0(r_win[1]) + r_win[0];
    end

    // Sequencer: next state and datapath controls
    always_comb begin
        n_state     = r_state;
        n_word_cnt  = r_word_cnt;
        n_round     = r_round;
        n_hash      = r_hash;
        n_v         = r_v;
        n_win       = r_win;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_in_stall  = (r_state != S_LOAD);

        unique case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (i_in_data.new_message) begin
                        n_hash = r_iv;
                    end
                    for (int i = 0; i < BlockWords - 1; i++) begin
                        n_win[i] = r_win[i+1];
                    end
                    n_win[BlockWords-1] = i_in_data.message_word;
                    n_word_cnt = r_word_cnt + 1'b1;
                    if (r_word_cnt == LastWord) begin
                        n_v     = n_hash;
                        n_round = '0;
                        n_state = S_ROUND;
                    end
                end
            end
            S_ROUND: begin
                // Advance the working variables and slide the schedule window
                n_v[7] = r_v[6];
                n_v[6] = r_v[5];
                n_v[5] = r_v[4];
                n_v[4] = r_v[3] + t1;
                n_v[3] = r_v[2];
                n_v[2] = r_v[1];
                n_v[1] = r_v[0];
                n_v[0] = t1 + t2;
                for (int i = 0; i < BlockWords - 1; i++) begin
                    n_win[i] = r_win[i+1];
                end
                n_win[BlockWords-1] = w_next;
                n_round = r_round + 1'b1;
                if (r_round == LastRound) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                // Hold until the output register is free, then fold and emit
                if (out_free) begin
                    for (int i = 0; i < NumIv; i++) begin
                        n_hash[i] = r_hash[i] + r_v[i];
                    end
                    n_out.digest_01 = {n_hash[0], n_hash[1]};
                    n_out.digest_23 = {n_hash[2], n_hash[3]};
                    n_out.digest_45 = {n_hash[4], n_hash[5]};
                    n_out.digest_67 = {n_hash[6], n_hash[7]};
                    n_out_valid     = 1'b1;
                    n_state         = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Control, IV and hash registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_word_cnt  <= '0;
            r_round     <= '0;
            r_out_valid <= 1'b0;
            r_iv        <= StdIv;
            r_hash      <= StdIv;
        end else begin
            r_state     <= n_state;
            r_word_cnt  <= n_word_cnt;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
            r_hash      <= n_hash;
            if (i_cfg_we && i_cfg_index <= CfgIvLast) begin
                r_iv[i_cfg_index[IvIdxW-1:0]] <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_v   <= n_v;
        r_win <= n_win;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The sixteenth word of a block starts the rounds and closes the input
    a_last_word_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && r_word_cnt == LastWord |=> o_in_stall && r_round == '0)
        else $error("last word did not start the rounds");

    // The word counter is back at zero whenever the engine is busy
    a_cnt_idle_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_LOAD |-> r_word_cnt == '0)
        else $error("word counter nonzero during compression");

    // A digest appears only out of the final cycle
    a_digest_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_FINAL)
        else $error("digest valid without a completed compression");

    // Leaving the final cycle always loads a fresh digest
    a_final_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FINAL && out_free |=> o_out_valid && r_state == S_LOAD)
        else $error("final cycle did not emit a digest");

endmodule

// ===== sim/sha256_block_compression_test.sv =====
module sha256_block_compression_test;
    import sha256bc_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    t_in_item   in_data = '0;
    logic       out_stall = 1'b0;
    logic       cfg_we = 1'b0;
    t_cfg_index cfg_index = '0;
    t_word      cfg_data = '0;
    logic       in_stall;
    logic       out_valid;
    t_out_item  out_data;

    // Predicted engine state
    t_word       iv_words [NumIv];
    t_word       hash_words [NumIv];
    t_word       block_buf [BlockWords];
    int unsigned word_pos = 0;

    t_in_item    word_queue [$];
    t_out_item   digest_queue [$];
    int unsigned error_count = 0;
    int unsigned send_idle_pct = 20;
    int unsigned recv_stall_pct = 47;

    sha256_block_compression dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_word rotr(t_word x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Run the 64 rounds over the buffered block and fold them into the hash
    function automatic void compress_block();
        t_word sched [Rounds];
        t_word v [NumIv];
        t_word lo, hi, t1, t2;
        for (int i = 0; i < NumIv; i++) v[i] = hash_words[i];
        for (int t = 0; t < Rounds; t++) begin
            if (t < BlockWords) begin
                sched[t] = block_buf[t];
            end else begin
                hi = sched[t-2];
                lo = sched[t-15];
                sched[t] = (rotr(hi, 17) ^ rotr(hi, 19) ^ (hi >> 10)) + sched[t-7]
                         + (rotr(lo, 7) ^ rotr(lo, 18) ^ (lo >> 3)) + sched[t-16];
            end
        end
        for (int t = 0; t < Rounds; t++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + sched[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int i = 7; i > 0; i--) v[i] = v[i-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < NumIv; i++) hash_words[i] = hash_words[i] + v[i];
    endfunction

    // Take one accepted word; a full block yields one expected digest
    function automatic void absorb_word(t_in_item item);
        t_out_item d;
        if (item.new_message) begin
            for (int i = 0; i < NumIv; i++) hash_words[i] = iv_words[i];
        end
        block_buf[word_pos] = item.message_word;
        word_pos = (word_pos + 1) % BlockWords;
        if (word_pos == 0) begin
            compress_block();
            d.digest_01 = {hash_words[0], hash_words[1]};
            d.digest_23 = {hash_words[2], hash_words[3]};
            d.digest_45 = {hash_words[4], hash_words[5]};
            d.digest_67 = {hash_words[6], hash_words[7]};
            digest_queue.push_back(d);
        end
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: digest mismatch on %s: got %h, want %h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic check_digest(t_out_item got);
        t_out_item want;
        if (digest_queue.size() == 0) begin
            report_mismatch("unexpected beat", got.digest_01, '0);
        end else begin
            want = digest_queue.pop_front();
            if (got.digest_01 !== want.digest_01)
                report_mismatch("digest_01", got.digest_01, want.digest_01);
            if (got.digest_23 !== want.digest_23)
                report_mismatch("digest_23", got.digest_23, want.digest_23);
            if (got.digest_45 !== want.digest_45)
                report_mismatch("digest_45", got.digest_45, want.digest_45);
            if (got.digest_67 !== want.digest_67)
                report_mismatch("digest_67", got.digest_67, want.digest_67);
        end
    endtask

    function automatic t_word rand_word();
        int unsigned pick;
        pick = $urandom_range(19);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return $urandom();
    endfunction

    function automatic void queue_word(t_word w, bit flag);
        t_in_item item;
        item.message_word = w;
        item.new_message = flag;
        word_queue.push_back(item);
    endfunction

    // One block; a rare flag lands in mid-block to break the sequence
    function automatic void queue_block(bit fresh);
        for (int i = 0; i < BlockWords; i++)
            queue_word(rand_word(), (i == 0) ? fresh : ($urandom_range(49) == 0));
    endfunction

    // Messages of one to four blocks, most starting with a reload
    function automatic void queue_messages(int unsigned n_blocks);
        int unsigned left, len;
        bit fresh;
        left = n_blocks;
        while (left != 0) begin
            len = $urandom_range(4, 1);
            if (len > left) len = left;
            fresh = ($urandom_range(9) != 0);
            for (int b = 0; b < len; b++) queue_block(b == 0 && fresh);
            left -= len;
        end
    endfunction

    // Hold until every word is taken and every digest is in, then settle
    task automatic drain(int unsigned settle);
        while (word_queue.size() != 0 || in_valid || digest_queue.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Write all IV registers, then one random index above the last IV
    task automatic load_ivs(t_word vals [NumIv]);
        for (int i = 0; i <= NumIv; i++) begin
            cfg_we <= 1'b1;
            if (i < NumIv) begin
                cfg_index <= t_cfg_index'(i);
                cfg_data <= vals[i];
                iv_words[i] = vals[i];
            end else begin
                cfg_index <= t_cfg_index'($urandom_range(15, NumIv));
                cfg_data <= $urandom();
            end
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Driver: present queued words, hold while stalled
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && !in_stall) absorb_word(in_data);
            if (!in_valid || !in_stall) begin
                if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data <= word_queue.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each digest beat, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) check_digest(out_data);
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial begin
        t_word iv_set [NumIv];
        for (int i = 0; i < NumIv; i++) begin
            iv_words[i] = StdIv[i];
            hash_words[i] = StdIv[i];
            block_buf[i] = '0;
            block_buf[i + NumIv] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 6; phase++) begin
            if (phase < 2) begin
                send_idle_pct = 20;
                recv_stall_pct = 47;
            end else if (phase < 4) begin
                send_idle_pct = 47;
                recv_stall_pct = 20;
            end else begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end

            // New IV setting per phase: extremes, random, then standard
            if (phase != 0) begin
                for (int i = 0; i < NumIv; i++) begin
                    case (phase)
                        1: iv_set[i] = '0;
                        2: iv_set[i] = '1;
                        5: iv_set[i] = StdIv[i];
                        default: iv_set[i] = $urandom();
                    endcase
                end
                load_ivs(iv_set);
            end

            if (phase == 0) begin
                // Standard "abc" block
                queue_word(32'h61626380, 1'b1);
                for (int i = 0; i < 14; i++) queue_word('0, 1'b0);
                queue_word(32'h00000018, 1'b0);
                // Extreme words with reloads in mid-block
                queue_word('1, 1'b1);
                queue_word('1, 1'b0);
                queue_word('0, 1'b0);
                queue_word('1, 1'b1);
                queue_word('0, 1'b1);
                queue_word('1, 1'b0);
                queue_word(32'h80000000, 1'b0);
                queue_word(32'h00000001, 1'b1);
                for (int i = 0; i < 8; i++) queue_word(rand_word(), 1'b0);
            end

            queue_messages(9);
            // Hold the sender until the engine has emptied out
            drain(0);
            queue_messages(9);
            drain(100);
        end

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sha256bc_pkg.sv
rtl/sha256_block_compression.sv
sim/sha256_block_compression_test.sv
